// ----- sv/bgc_pkg.sv -----
// Package with the shared types and constants of the bipartite graph checker.
package bgc_pkg;

  localparam int VertexWidth = 6;
  localparam int CountWidth  = 7;

  localparam logic CmdAddEdge = 1'b0;
  localparam logic CmdRun     = 1'b1;

  typedef struct packed {
    logic                   cmd;
    logic [VertexWidth-1:0] vertex_a;
    logic [VertexWidth-1:0] vertex_b;
  } in_word_t;

  typedef struct packed {
    logic is_bipartite;
    logic bad_edge_seen;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_edge;
    logic bad_edge;
    logic run_start;
    logic clear_start;
    logic result_taken;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic edge_in_range;
    logic search_done;
    logic clear_done;
  } dp_status_t;

endpackage

// ----- sv/bgc_datapath.sv -----
// Datapath: adjacency matrix, colors, search stack and result registers.
module bgc_datapath #(
  parameter int MaxVertices = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [bgc_pkg::CountWidth-1:0]    vertex_count,
  input  bgc_pkg::in_word_t                 in_word,
  input  bgc_pkg::dp_cmd_t                  cmd,
  output bgc_pkg::dp_status_t               status,
  output bgc_pkg::out_word_t                result
);

  localparam int IdxW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int CntW = $clog2(MaxVertices + 1);
  localparam int SrcW = (bgc_pkg::CountWidth > CntW) ? bgc_pkg::CountWidth : CntW;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_NEXT_S = 5'b00010,
    PH_POP    = 5'b00100,
    PH_ROW    = 5'b01000,
    PH_SCAN   = 5'b10000
  } phase_t;

  logic [MaxVertices-1:0] adj [MaxVertices];
  logic [MaxVertices-1:0] colored;
  logic [MaxVertices-1:0] color;
  logic [IdxW-1:0]        stack_mem [MaxVertices];
  logic [CntW-1:0]        stack_depth;
  logic                   bad_flag;
  phase_t                 phase;
  logic [CntW-1:0]        start_v;
  logic [IdxW-1:0]        cur_u;
  logic [CntW-1:0]        scan_v;
  logic [MaxVertices-1:0] cur_row;
  logic                   search_done;
  logic                   is_bip;
  logic [CntW-1:0]        clr_idx;
  logic                   clr_busy;
  logic [CntW-1:0]        n_eff;
  logic [SrcW-1:0]        a_ext, b_ext, cnt_ext;
  logic [IdxW-1:0]        a_idx, b_idx;

  // Effective count is the register limited to the matrix size.
  assign cnt_ext = SrcW'(vertex_count);
  assign n_eff = (cnt_ext > SrcW'(MaxVertices)) ? CntW'(MaxVertices) : CntW'(cnt_ext);
  assign a_ext = SrcW'(in_word.vertex_a);
  assign b_ext = SrcW'(in_word.vertex_b);
  assign a_idx = IdxW'(in_word.vertex_a);
  assign b_idx = IdxW'(in_word.vertex_b);
  assign status.edge_in_range = (a_ext < SrcW'(n_eff)) && (b_ext < SrcW'(n_eff));
  assign status.search_done = search_done;
  assign status.clear_done = !clr_busy;
  assign result.is_bipartite = is_bip;
  assign result.bad_edge_seen = bad_flag;

  // Matrix writes: edge loads set two bits, the clearing pass zeroes one row a cycle.
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      adj[clr_idx[IdxW-1:0]] <= '0;
    end else if (cmd.load_edge) begin
      adj[a_idx][b_idx] <= 1'b1;
      adj[b_idx][a_idx] <= 1'b1;
    end
  end

  // Clearing pass after each run; also run once after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (cmd.clear_start) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      if (clr_idx == CntW'(MaxVertices - 1)) begin
        clr_busy <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // Sticky bad-edge flag, cleared when the result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      bad_flag <= 1'b0;
    end else if (cmd.bad_edge) begin
      bad_flag <= 1'b1;
    end else if (cmd.result_taken) begin
      bad_flag <= 1'b0;
    end
  end

  // Stack memory, written on push.
  logic            push;
  logic [IdxW-1:0] push_v;
  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[stack_depth[IdxW-1:0]] <= push_v;
    end
  end

  logic edge_hit;
  assign edge_hit = cur_row[scan_v[IdxW-1:0]];

  // Depth-first search: one neighbor tested each cycle.
  always_comb begin
    push   = 1'b0;
    push_v = scan_v[IdxW-1:0];
    if (phase == PH_NEXT_S && start_v < n_eff && !colored[start_v[IdxW-1:0]]) begin
      push   = 1'b1;
      push_v = start_v[IdxW-1:0];
    end else if (phase == PH_SCAN && scan_v < n_eff && edge_hit
                 && !colored[scan_v[IdxW-1:0]]) begin
      push = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      search_done <= 1'b0;
      stack_depth <= '0;
    end else begin
      case (phase)
        PH_IDLE: begin
          if (cmd.run_start) begin
            phase       <= PH_NEXT_S;
            search_done <= 1'b0;
            colored     <= '0;
            start_v     <= '0;
            is_bip      <= 1'b1;
            stack_depth <= '0;
          end else if (cmd.result_taken) begin
            search_done <= 1'b0;
          end
        end
        PH_NEXT_S: begin
          if (start_v >= n_eff) begin
            phase       <= PH_IDLE;
            search_done <= 1'b1;
          end else begin
            if (!colored[start_v[IdxW-1:0]]) begin
              colored[start_v[IdxW-1:0]] <= 1'b1;
              color[start_v[IdxW-1:0]]   <= 1'b0;
              stack_depth <= stack_depth + 1'b1;
              phase       <= PH_POP;
            end
            start_v <= start_v + 1'b1;
          end
        end
        PH_POP: begin
          if (stack_depth == '0) begin
            phase <= PH_NEXT_S;
          end else begin
            cur_u       <= stack_mem[stack_depth[IdxW-1:0] - 1'b1];
            stack_depth <= stack_depth - 1'b1;
            phase       <= PH_ROW;
          end
        end
        // Fetch the adjacency row of the popped vertex.
        PH_ROW: begin
          cur_row <= adj[cur_u];
          scan_v  <= '0;
          phase   <= PH_SCAN;
        end
        PH_SCAN: begin
          if (scan_v >= n_eff) begin
            phase <= PH_POP;
          end else begin
            if (edge_hit) begin
              if (!colored[scan_v[IdxW-1:0]]) begin
                colored[scan_v[IdxW-1:0]] <= 1'b1;
                color[scan_v[IdxW-1:0]]   <= ~color[cur_u];
                stack_depth <= stack_depth + 1'b1;
              end else if (color[scan_v[IdxW-1:0]] == color[cur_u]) begin
                is_bip      <= 1'b0;
                phase       <= PH_IDLE;
                search_done <= 1'b1;
              end
            end
            scan_v <= scan_v + 1'b1;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/bgc_ctrl.sv -----
// Controller state machine that sequences edge loads, runs and clearing.
module bgc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bgc_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_ready,
  input  bgc_pkg::dp_status_t status,
  output bgc_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_REPORT = 4'b0100,
    ST_CLEAR  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready  = (state == ST_IDLE) && status.clear_done;
  assign out_valid = (state == ST_REPORT);
  assign accept    = in_valid && in_ready;

  // Command decode.
  always_comb begin
    cmd = '0;
    cmd.load_edge    = accept && in_word.cmd == bgc_pkg::CmdAddEdge && status.edge_in_range;
    cmd.bad_edge     = accept && in_word.cmd == bgc_pkg::CmdAddEdge && !status.edge_in_range;
    cmd.run_start    = accept && in_word.cmd == bgc_pkg::CmdRun;
    cmd.result_taken = (state == ST_REPORT) && out_ready;
    cmd.clear_start  = cmd.result_taken;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (cmd.run_start) state_next = ST_SEARCH;
      ST_SEARCH: if (status.search_done) state_next = ST_REPORT;
      ST_REPORT: if (out_ready) state_next = ST_CLEAR;
      ST_CLEAR:  state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/bipartite_graph_check.sv -----
// Top level of the bipartite graph checker.
// Usage: the input channel (in_valid, in_ready, in_word) takes one word per
// command. An add-edge word sets two adjacency bits; an edge with an
// endpoint at or beyond vertex_count (limited to MAX_VERTICES) is dropped
// and sets the sticky bad-edge flag. No result comes from an edge load.
// A run word starts a depth-first two-coloring search. The datapath tests
// one neighbor per cycle: it steps through the start vertices, pops each
// vertex from the stack, fetches its adjacency row and scans it, and stops
// early at the first edge whose ends have the same color.
// One result word then appears on out_valid / out_word and holds until
// out_ready; while the receiver stalls no new word is accepted.
// After the result is taken a clearing pass zeroes the matrix, one row a
// cycle, during which in_ready is low. The same pass runs right after
// reset. vertex_count resets to 64; the user writes it through cfg_we /
// cfg_data only while the block is idle; the block does not enforce this.
module bipartite_graph_check #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bgc_pkg::CountWidth-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bgc_pkg::in_word_t              in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bgc_pkg::out_word_t             out_word
);

  logic [bgc_pkg::CountWidth-1:0] vertex_count;
  bgc_pkg::dp_cmd_t    cmd;
  bgc_pkg::dp_status_t status;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= bgc_pkg::CountWidth'(64);
    end else if (cfg_we) begin
      vertex_count <= cfg_data;
    end
  end

  bgc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_word(in_word), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .cmd(cmd)
  );

  bgc_datapath #(.MaxVertices(MAX_VERTICES)) u_dp (
    .clk(clk), .rst(rst), .vertex_count(vertex_count), .in_word(in_word),
    .cmd(cmd), .status(status), .result(out_word)
  );

endmodule

// ----- tb/sv/bipartite_graph_check_tb.sv -----
// Self-checking testbench for the bipartite graph checker.
module bipartite_graph_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxVert = 64;
  localparam int IdleLimit = 20000;
  localparam int TailCycles = 200;
  localparam logic [1:0] Uncolored = 2'd2;

  logic clk, rst;
  logic cfg_we;
  logic [bgc_pkg::CountWidth-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  bgc_pkg::in_word_t in_word;
  bgc_pkg::out_word_t out_word;

  bipartite_graph_check #(.MAX_VERTICES(MaxVert)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

  // Predictor state.
  logic [MaxVert-1:0] adj [MaxVert];
  logic bad_flag;
  int unsigned vcount;
  bgc_pkg::out_word_t verdicts [$];
  int errors;
  int idle_cycles;
  bit hold_off;

  // Directed table: a known verdict is checked only where known is set.
  typedef struct {
    bgc_pkg::in_word_t w;
    bit known;
    bgc_pkg::out_word_t v;
  } dir_row_t;

  dir_row_t rows [$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Two-color search over the predicted matrix.
  function automatic bit two_colorable(int unsigned n);
    logic [1:0] color [MaxVert];
    int stk [MaxVert];
    int sp, u;
    for (int i = 0; i < MaxVert; i++) color[i] = Uncolored;
    for (int s = 0; s < n; s++) begin
      if (color[s] != Uncolored) continue;
      color[s] = 2'd0;
      stk[0] = s;
      sp = 1;
      while (sp > 0) begin
        sp = sp - 1;
        u = stk[sp];
        for (int v = 0; v < n; v++) begin
          if (!adj[u][v]) continue;
          if (color[v] == Uncolored) begin
            color[v] = 2'd1 - color[u];
            stk[sp] = v;
            sp = sp + 1;
          end else if (color[v] == color[u]) begin
            return 1'b0;
          end
        end
      end
    end
    return 1'b1;
  endfunction

  // Apply one accepted word to the predictor.
  function automatic void predict_word(bgc_pkg::in_word_t w);
    int unsigned n;
    bgc_pkg::out_word_t r;
    n = (vcount > MaxVert) ? MaxVert : vcount;
    if (w.cmd == bgc_pkg::CmdAddEdge) begin
      if (w.vertex_a >= n || w.vertex_b >= n) bad_flag = 1'b1;
      else begin
        adj[w.vertex_a][w.vertex_b] = 1'b1;
        adj[w.vertex_b][w.vertex_a] = 1'b1;
      end
    end else begin
      r.is_bipartite = two_colorable(n);
      r.bad_edge_seen = bad_flag;
      verdicts.insert(verdicts.size(), r);
      for (int i = 0; i < MaxVert; i++) adj[i] = '0;
      bad_flag = 1'b0;
    end
  endfunction

  // Predict at each accepted input word.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) predict_word(in_word);
  end

  // Compare each result word with the oldest verdict.
  always @(posedge clk) begin
    bgc_pkg::out_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (verdicts.size() == 0) begin
        $display("%0t: unexpected result word %b", $time, out_word);
        errors++;
      end else begin
        e = verdicts.pop_front();
        if (e.is_bipartite !== out_word.is_bipartite) begin
          $display("%0t: is_bipartite expected %b actual %b", $time,
                   e.is_bipartite, out_word.is_bipartite);
          errors++;
        end
        if (e.bad_edge_seen !== out_word.bad_edge_seen) begin
          $display("%0t: bad_edge_seen expected %b actual %b", $time,
                   e.bad_edge_seen, out_word.bad_edge_seen);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("bipartite_graph_check_tb failed");
      $finish;
    end
  end

  // Receiver: own stall pattern, plus one long hold-off.
  initial begin
    int mode;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      mode = $urandom_range(0, 9);
      if (mode < 3) out_ready <= 1'b1;
      else if (mode < 5) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Drive one word and wait for its acceptance; valid stays high for the
  // caller to either offer the next word or drop it at the same edge.
  task automatic send_word(bgc_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Wait until every verdict has come, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (verdicts.size() != 0) @(negedge clk);
    repeat (TailCycles) @(negedge clk);
  endtask

  task automatic write_count(logic [bgc_pkg::CountWidth-1:0] c);
    cfg_we <= 1'b1;
    cfg_data <= c;
    @(negedge clk);
    cfg_we <= 1'b0;
    vcount = c;
  endtask

  function automatic bgc_pkg::in_word_t mk(logic c, int a, int b);
    bgc_pkg::in_word_t w;
    w.cmd = c;
    w.vertex_a = a[bgc_pkg::VertexWidth-1:0];
    w.vertex_b = b[bgc_pkg::VertexWidth-1:0];
    return w;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(bit k, bgc_pkg::out_word_t v, bgc_pkg::in_word_t w);
    dir_row_t r;
    r.known = k;
    r.v = v;
    r.w = w;
    rows.insert(rows.size(), r);
  endfunction

  // Random vertex, mostly in range of n.
  function automatic int pick_vertex(int unsigned n);
    if (n == 0 || $urandom_range(0, 19) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, (n > MaxVert ? MaxVert : n) - 1);
  endfunction

  // Send one word with a burst-style gap before it.
  task automatic send_gapped(bgc_pkg::in_word_t w, ref int burst);
    int gap;
    if (burst == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst = $urandom_range(1, 12);
    end
    burst--;
    send_word(w);
  endtask

  initial begin
    int burst, edges, ring, sent;
    logic [bgc_pkg::CountWidth-1:0] counts [6];
    int unsigned n;
    counts = '{7'd1, 7'd2, 7'd64, 7'd127, 7'd0, 7'd9};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_word = '0;
    errors = 0;
    hold_off = 1'b0;
    bad_flag = 1'b0;
    vcount = 64;
    for (int i = 0; i < MaxVert; i++) adj[i] = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Directed table at reset count 64.
    add_row(1'b1, '{1'b1, 1'b0}, mk(bgc_pkg::CmdRun, 0, 0));
    add_row(1'b0, '0, mk(bgc_pkg::CmdAddEdge, 0, 63));
    add_row(1'b0, '0, mk(bgc_pkg::CmdAddEdge, 63, 0));
    add_row(1'b1, '{1'b1, 1'b0}, mk(bgc_pkg::CmdRun, 63, 63));
    add_row(1'b0, '0, mk(bgc_pkg::CmdAddEdge, 5, 5));
    add_row(1'b1, '{1'b0, 1'b0}, mk(bgc_pkg::CmdRun, 0, 0));
    add_row(1'b0, '0, mk(bgc_pkg::CmdAddEdge, 1, 2));
    add_row(1'b0, '0, mk(bgc_pkg::CmdAddEdge, 2, 3));
    add_row(1'b0, '0, mk(bgc_pkg::CmdAddEdge, 3, 1));
    add_row(1'b0, '0, mk(bgc_pkg::CmdRun, 0, 0));
    add_row(1'b0, '0, mk(bgc_pkg::CmdAddEdge, 10, 11));
    add_row(1'b0, '0, mk(bgc_pkg::CmdAddEdge, 11, 12));
    add_row(1'b0, '0, mk(bgc_pkg::CmdAddEdge, 12, 13));
    add_row(1'b0, '0, mk(bgc_pkg::CmdAddEdge, 13, 10));
    add_row(1'b0, '0, mk(bgc_pkg::CmdRun, 0, 0));
    foreach (rows[i]) begin
      send_word(rows[i].w);
      if (rows[i].known && rows[i].w.cmd == bgc_pkg::CmdRun && verdicts.size() > 0 &&
          verdicts[$] != rows[i].v) begin
        $display("%0t: directed row %0d expected %b predicted %b", $time, i,
                 rows[i].v, verdicts[$]);
        errors++;
      end
    end
    drain();

    // Small counts: out-of-range edge, zero count, count above the limit.
    write_count(7'd4);
    send_word(mk(bgc_pkg::CmdAddEdge, 4, 0));
    send_word(mk(bgc_pkg::CmdAddEdge, 0, 3));
    send_word(mk(bgc_pkg::CmdRun, 0, 0));
    drain();
    write_count(7'd0);
    send_word(mk(bgc_pkg::CmdAddEdge, 0, 0));
    send_word(mk(bgc_pkg::CmdRun, 0, 0));
    drain();
    write_count(7'd127);
    send_word(mk(bgc_pkg::CmdAddEdge, 63, 62));
    send_word(mk(bgc_pkg::CmdAddEdge, 42, 21));
    send_word(mk(bgc_pkg::CmdRun, 0, 0));
    drain();

    // Random phases: graphs of random edges, rings and noise.
    burst = 0;
    sent = 0;
    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 6) write_count(counts[ph]);
      else write_count(bgc_pkg::CountWidth'($urandom_range(0, 20) == 0 ? 64 :
                                            $urandom_range(1, 16)));
      n = vcount > MaxVert ? MaxVert : vcount;
      if (ph == 3) hold_off = 1'b1;
      while (sent < (ph + 1) * 100) begin
        ring = $urandom_range(0, 3);
        edges = $urandom_range(0, (n > 16) ? 8 : n + 2);
        if (ring == 0 && n >= 2) begin
          // Cycle of random length: even ones are bipartite.
          int len;
          len = $urandom_range(2, (n < 9) ? n : 9);
          for (int k = 0; k < len; k++) begin
            send_gapped(mk(bgc_pkg::CmdAddEdge, k, (k + 1) % len), burst);
            sent++;
          end
        end
        for (int k = 0; k < edges; k++) begin
          send_gapped(mk(bgc_pkg::CmdAddEdge, pick_vertex(n), pick_vertex(n)), burst);
          sent++;
        end
        send_gapped(mk(bgc_pkg::CmdRun, $urandom_range(0, 63), $urandom_range(0, 63)),
                    burst);
        sent++;
        if (ph == 7 && sent % 50 < 5) drain();
      end
      drain();
    end

    if (errors == 0 && verdicts.size() == 0) begin
      $display("bipartite_graph_check_tb passed");
    end else begin
      $display("bipartite_graph_check_tb failed");
    end
    $finish;
  end

endmodule
